>>> rtl/core/uve_pkg.sv
`default_nettype none

package uve_pkg;

    // One encoded value, waiting to be sent out one byte at a time
    typedef struct packed {
        logic [7:0] lo_byte;
        logic [7:0] hi_byte;
        logic [7:0] key_byte;
        logic       has_hi;
        logic       has_key;
    } t_item;

    // Stream codes on the result channel
    localparam logic SEL_DATA = 1'b0;
    localparam logic SEL_KEY  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/uve_pack.sv
`default_nettype none

module uve_pack (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [15:0]   i_value,
    input  wire logic          i_final_value,
    output logic               o_stall,
    input  wire logic          i_pop,
    output logic               o_item_vld,
    output uve_pkg::t_item     o_item
);

    logic [7:0]     r_key_accum;
    logic [2:0]     r_slot_count;
    logic           r_item_vld;
    uve_pkg::t_item r_item;

    logic           w_accept;
    logic           w_is_long;
    logic [7:0]     n_key_accum;
    logic [2:0]     n_slot_count;
    logic           w_has_key;

    // Hold the input while the item register is busy and not being released
    assign o_stall  = r_item_vld && !i_pop;
    assign w_accept = i_valid && !o_stall;

    // Classify the value and fold its key bit into the group
    always_comb begin
        w_is_long    = (i_value[15:8] != 8'h00);
        n_key_accum  = r_key_accum | (8'(w_is_long) << r_slot_count);
        n_slot_count = r_slot_count + 3'd1;
        w_has_key    = (n_slot_count == 3'd0) || i_final_value;
    end

    // Advance group state and load the item register on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_accum  <= 8'h00;
            r_slot_count <= 3'd0;
            r_item_vld   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_item_vld <= 1'b1;
                if (w_has_key) begin
                    r_key_accum  <= 8'h00;
                    r_slot_count <= 3'd0;
                end else begin
                    r_key_accum  <= n_key_accum;
                    r_slot_count <= n_slot_count;
                end
            end else if (i_pop) begin
                r_item_vld <= 1'b0;
            end
        end
    end

    // Payload of the item register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.lo_byte  <= i_value[7:0];
            r_item.hi_byte  <= i_value[15:8];
            r_item.key_byte <= n_key_accum;
            r_item.has_hi   <= w_is_long;
            r_item.has_key  <= w_has_key;
        end
    end

    assign o_item_vld = r_item_vld;
    assign o_item     = r_item;

endmodule

`default_nettype wire

>>> rtl/core/uve_ser.sv
`default_nettype none

module uve_ser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_vld,
    input  wire uve_pkg::t_item  i_item,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_stream_sel,
    output logic                 o_run_end
);

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_KEY
    } t_phase;

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_valid;
    logic [7:0] r_out_byte;
    logic       r_stream_sel;
    logic       r_run_end;

    logic       w_load;
    logic [7:0] w_byte;
    logic       w_sel;
    logic       w_last;

    // The output register takes a new byte when empty or being drained
    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && i_item_vld && w_last;

    // Pick the byte for the current phase and the phase after it
    always_comb begin
        case (r_phase)
            PH_LO: begin
                w_byte  = i_item.lo_byte;
                w_sel   = uve_pkg::SEL_DATA;
                w_last  = !i_item.has_hi && !i_item.has_key;
                n_phase = i_item.has_hi ? PH_HI : PH_KEY;
            end
            PH_HI: begin
                w_byte  = i_item.hi_byte;
                w_sel   = uve_pkg::SEL_DATA;
                w_last  = !i_item.has_key;
                n_phase = PH_KEY;
            end
            PH_KEY: begin
                w_byte  = i_item.key_byte;
                w_sel   = uve_pkg::SEL_KEY;
                w_last  = 1'b1;
                n_phase = PH_LO;
            end
            default: begin
                w_byte  = i_item.lo_byte;
                w_sel   = uve_pkg::SEL_DATA;
                w_last  = 1'b1;
                n_phase = PH_LO;
            end
        endcase
    end

    // Step through the item's bytes and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LO;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_item_vld;
            if (i_item_vld) begin
                r_phase      <= w_last ? PH_LO : n_phase;
                r_out_byte   <= w_byte;
                r_stream_sel <= w_sel;
                r_run_end    <= w_last;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_out_byte;
    assign o_stream_sel = r_stream_sel;
    assign o_run_end    = r_run_end;

endmodule

`default_nettype wire

>>> rtl/core/uint16_varint_bitmap_encoder_core.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_value[15:0], i_final_value
// result    out        o_valid / i_stall  o_out_byte[7:0], o_stream_sel, o_run_end
//
// Each value gives one to three result bytes: 1 + (value >= 256) + (key byte due);
// the result port moves one byte per cycle while i_stall is low.
// Input reaches the result port through the item register, then the output register.
// Reset (synchronous, active low) clears the key group and empties both registers.
// A stall on the result side holds the output register; the item register keeps taking
// input until it is full.
`default_nettype none

module uint16_varint_bitmap_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_value,
    input  wire logic        i_final_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_stream_sel,
    output logic             o_run_end
);

    logic           w_item_vld;
    logic           w_pop;
    uve_pkg::t_item w_item;

    // Encode value and collect key bits
    uve_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_value       (i_value),
        .i_final_value (i_final_value),
        .o_stall       (o_stall),
        .i_pop         (w_pop),
        .o_item_vld    (w_item_vld),
        .o_item        (w_item)
    );

    // Send the item's bytes one per cycle while the result side does not stall
    uve_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_vld   (w_item_vld),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_stream_sel (o_stream_sel),
        .o_run_end    (o_run_end)
    );

    // A key byte always closes its item's results
    a_key_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_sel == uve_pkg::SEL_KEY) |-> o_run_end)
        else $error("key byte without run end");

    // The rest of an item follows without a gap
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_run_end) |=> o_valid)
        else $error("gap inside an item's results");

    // An item is released only when it is being sent
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_vld)
        else $error("item released while empty");

endmodule

`default_nettype wire
